### hdl/fcbp_pkg.sv
// fcbp_pkg: shared types and constants of the framed command byte parser
// no dependencies; used by fcbp_cfg_regs, fcbp_parser, fcbp_out_stage, the top level and the bench
`default_nettype none

package fcbp_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] ReadFailWord = 16'hDEAD;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_WORD   = 3'd0,
    REG_WRITE_CODE  = 3'd1,
    REG_READ_CODE   = 3'd2,
    REG_STREAM_CODE = 3'd3,
    REG_GPIO_LOW    = 3'd4,
    REG_GPIO_HIGH   = 3'd5,
    REG_PWM_LOW     = 3'd6,
    REG_PWM_HIGH    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_SYNC1 = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_CMD   = 4'd2,
    PH_ADDR1 = 4'd3,
    PH_ADDR2 = 4'd4,
    PH_VAL1  = 4'd5,
    PH_VAL2  = 4'd6,
    PH_LEN   = 4'd7,
    PH_PAY   = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ACT_PWM_WR   = 3'd0,
    ACT_GPIO_WR  = 3'd1,
    ACT_GPIO_RD  = 3'd2,
    ACT_RD_REPLY = 3'd3,
    ACT_STREAM   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_STREAM = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] sync_word;
    logic [7:0]  write_code;
    logic [7:0]  read_code;
    logic [7:0]  stream_code;
    logic [15:0] gpio_low;
    logic [15:0] gpio_high;
    logic [15:0] pwm_low;
    logic [15:0] pwm_high;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] target_address;
    logic [15:0] data_word;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_length;
    logic        last_of_stream;
  } result_t;

endpackage

`default_nettype wire

### hdl/fcbp_in_if.sv
// fcbp_in_if: received byte channel (valid/ready plus one byte)
// no dependencies
`default_nettype none

interface fcbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/fcbp_out_if.sv
// fcbp_out_if: result channel (valid/ready plus one parsed action)
// no dependencies
`default_nettype none

interface fcbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] target_address;
  logic [15:0] data_word;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_length;
  logic        last_of_stream;

  modport source (
    output valid, output action, output target_address, output data_word,
    output payload_byte, output payload_length, output last_of_stream,
    input ready
  );
  modport sink (
    input valid, input action, input target_address, input data_word,
    input payload_byte, input payload_length, input last_of_stream,
    output ready
  );
endinterface

`default_nettype wire

### hdl/fcbp_cfg_if.sv
// fcbp_cfg_if: configuration write channel (valid/ready, index, data)
// no dependencies
`default_nettype none

interface fcbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### hdl/fcbp_cfg_regs.sv
// fcbp_cfg_regs: configuration register file of the parser
// depends on fcbp_pkg
`default_nettype none

module fcbp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [fcbp_pkg::CfgIdxW-1:0]  wr_index,
  input  wire logic [fcbp_pkg::CfgDataW-1:0] wr_data,
  output fcbp_pkg::cfg_t                      cfg
);

  fcbp_pkg::cfg_t cfg_r;
  fcbp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (fcbp_pkg::reg_idx_t'(wr_index))
        fcbp_pkg::REG_SYNC_WORD:   cfg_nxt.sync_word   = wr_data;
        fcbp_pkg::REG_WRITE_CODE:  cfg_nxt.write_code  = wr_data[7:0];
        fcbp_pkg::REG_READ_CODE:   cfg_nxt.read_code   = wr_data[7:0];
        fcbp_pkg::REG_STREAM_CODE: cfg_nxt.stream_code = wr_data[7:0];
        fcbp_pkg::REG_GPIO_LOW:    cfg_nxt.gpio_low    = wr_data;
        fcbp_pkg::REG_GPIO_HIGH:   cfg_nxt.gpio_high   = wr_data;
        fcbp_pkg::REG_PWM_LOW:     cfg_nxt.pwm_low     = wr_data;
        fcbp_pkg::REG_PWM_HIGH:    cfg_nxt.pwm_high    = wr_data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### hdl/fcbp_parser.sv
// fcbp_parser: frame phase machine, one received byte per cycle
// depends on fcbp_pkg; produces at most one result per accepted byte
`default_nettype none

module fcbp_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire fcbp_pkg::cfg_t cfg,
  input  wire logic       byte_valid,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output fcbp_pkg::result_t res
);

  fcbp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  valhi_r, valhi_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  remain_r, remain_nxt;

  fcbp_pkg::kind_t byte_kind;
  fcbp_pkg::kind_t held_kind;
  logic [15:0]     full_addr;
  logic [15:0]     wr_value;
  logic            rd_in_gpio;
  logic            wr_in_gpio;
  logic            wr_in_pwm;

  function automatic fcbp_pkg::kind_t decode_kind(input logic [7:0] c,
                                                  input fcbp_pkg::cfg_t k);
    fcbp_pkg::kind_t r;
    if (c == k.write_code) r = fcbp_pkg::KIND_WRITE;
    else if (c == k.read_code) r = fcbp_pkg::KIND_READ;
    else if (c == k.stream_code) r = fcbp_pkg::KIND_STREAM;
    else r = fcbp_pkg::KIND_NONE;
    return r;
  endfunction

  assign byte_kind  = decode_kind(rx_byte, cfg);
  assign held_kind  = decode_kind(cmd_r, cfg);
  assign full_addr  = {addr_r[15:8], rx_byte};
  assign wr_value   = {valhi_r, rx_byte};
  assign rd_in_gpio = (full_addr >= cfg.gpio_low) && (full_addr <= cfg.gpio_high);
  assign wr_in_gpio = (addr_r >= cfg.gpio_low) && (addr_r <= cfg.gpio_high);
  assign wr_in_pwm  = (addr_r >= cfg.pwm_low) && (addr_r <= cfg.pwm_high);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    addr_nxt   = addr_r;
    valhi_nxt  = valhi_r;
    total_nxt  = total_r;
    remain_nxt = remain_r;
    if (byte_valid) begin
      case (phase_r)
        fcbp_pkg::PH_SYNC1: begin
          if (rx_byte == cfg.sync_word[15:8]) phase_nxt = fcbp_pkg::PH_SYNC2;
        end
        fcbp_pkg::PH_SYNC2: begin
          phase_nxt = (rx_byte == cfg.sync_word[7:0]) ? fcbp_pkg::PH_CMD
                                                     : fcbp_pkg::PH_SYNC1;
        end
        fcbp_pkg::PH_CMD: begin
          cmd_nxt   = rx_byte;
          phase_nxt = (byte_kind != fcbp_pkg::KIND_NONE) ? fcbp_pkg::PH_ADDR1
                                                         : fcbp_pkg::PH_SYNC1;
        end
        fcbp_pkg::PH_ADDR1: begin
          addr_nxt  = {rx_byte, 8'h00};
          phase_nxt = fcbp_pkg::PH_ADDR2;
        end
        fcbp_pkg::PH_ADDR2: begin
          addr_nxt = full_addr;
          case (held_kind)
            fcbp_pkg::KIND_WRITE:  phase_nxt = fcbp_pkg::PH_VAL1;
            fcbp_pkg::KIND_STREAM: phase_nxt = fcbp_pkg::PH_LEN;
            default:               phase_nxt = fcbp_pkg::PH_SYNC1;
          endcase
        end
        fcbp_pkg::PH_VAL1: begin
          valhi_nxt = rx_byte;
          phase_nxt = fcbp_pkg::PH_VAL2;
        end
        fcbp_pkg::PH_VAL2: begin
          phase_nxt = fcbp_pkg::PH_SYNC1;
        end
        fcbp_pkg::PH_LEN: begin
          total_nxt  = rx_byte;
          remain_nxt = rx_byte;
          phase_nxt  = (rx_byte == 8'd0) ? fcbp_pkg::PH_SYNC1 : fcbp_pkg::PH_PAY;
        end
        fcbp_pkg::PH_PAY: begin
          if (remain_r <= 8'd1) begin
            remain_nxt = 8'd0;
            phase_nxt  = fcbp_pkg::PH_SYNC1;
          end else begin
            remain_nxt = remain_r - 8'd1;
          end
        end
        default: begin
          phase_nxt = fcbp_pkg::PH_SYNC1;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    res.target_address = addr_r;
    case (phase_r)
      fcbp_pkg::PH_ADDR2: begin
        res.target_address = full_addr;
        if (held_kind == fcbp_pkg::KIND_READ) begin
          res_valid = byte_valid;
          if (rd_in_gpio) begin
            res.action = fcbp_pkg::ACT_GPIO_RD;
          end else begin
            res.action    = fcbp_pkg::ACT_RD_REPLY;
            res.data_word = fcbp_pkg::ReadFailWord;
          end
        end
      end
      fcbp_pkg::PH_VAL2: begin
        res.data_word = wr_value;
        if (wr_in_pwm) begin
          res_valid  = byte_valid;
          res.action = fcbp_pkg::ACT_PWM_WR;
        end else if (wr_in_gpio) begin
          res_valid  = byte_valid;
          res.action = fcbp_pkg::ACT_GPIO_WR;
        end
      end
      fcbp_pkg::PH_PAY: begin
        res_valid          = byte_valid;
        res.action         = fcbp_pkg::ACT_STREAM;
        res.payload_byte   = rx_byte;
        res.payload_length = total_r;
        res.last_of_stream = (remain_r <= 8'd1);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fcbp_pkg::PH_SYNC1;
      cmd_r    <= '0;
      addr_r   <= '0;
      valhi_r  <= '0;
      total_r  <= '0;
      remain_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      addr_r   <= addr_nxt;
      valhi_r  <= valhi_nxt;
      total_r  <= total_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/fcbp_out_stage.sv
// fcbp_out_stage: result register driving the result channel
// depends on fcbp_pkg and fcbp_out_if
`default_nettype none

module fcbp_out_stage (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         res_valid,
  input  wire fcbp_pkg::result_t res,
  output logic              can_take,
  fcbp_out_if.source        out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  fcbp_pkg::result_t data_r;

  assign can_take  = !valid_r || out_ch.ready;
  assign valid_nxt = can_take ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.action         = data_r.action;
  assign out_ch.target_address = data_r.target_address;
  assign out_ch.data_word      = data_r.data_word;
  assign out_ch.payload_byte   = data_r.payload_byte;
  assign out_ch.payload_length = data_r.payload_length;
  assign out_ch.last_of_stream = data_r.last_of_stream;

endmodule

`default_nettype wire

### hdl/framed_command_byte_parser_top.sv
// framed_command_byte_parser_top: top level of the framed command byte parser
// depends on fcbp_pkg, the fcbp channel interfaces, fcbp_cfg_regs,
// fcbp_parser and fcbp_out_stage
//
// usage:
//   in_ch carries one received byte per request (valid/ready). a frame is
//   sync byte, sync byte, command, address high, address low, then a
//   16-bit value (write), nothing (read), or a length and payload (stream).
//   out_ch carries at most one action per byte: pwm/gpio write, gpio read
//   request, 0xDEAD read reply, or one stream payload byte with a last mark.
//   cfg_ch writes the eight registers (sync word, command codes, windows);
//   it is always ready; the user must write it only while no frame is in
//   progress (not enforced). throughput: one byte per cycle unless out_ch
//   stalls. a result shows on out_ch in the cycle after its last byte is
//   taken; the phase machine and window compares feed the result register.
//   when out_ch stalls with a result held, in_ch.ready drops until the
//   result is taken; a result taken in the same cycle frees the slot at once.
//   reset (rst_n low, synchronous) zeroes the config and parser registers,
//   empties the result register; the parser waits for the first sync byte.
`default_nettype none

module framed_command_byte_parser_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fcbp_in_if.sink    in_ch,
  fcbp_out_if.source out_ch,
  fcbp_cfg_if.sink   cfg_ch
);

  fcbp_pkg::cfg_t    cfg;
  fcbp_pkg::result_t res;
  logic              res_valid;
  logic              can_take;
  logic              byte_take;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_take;
  assign byte_take    = in_ch.valid && can_take;

  fcbp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.wdata),
    .cfg      (cfg)
  );

  fcbp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .byte_valid (byte_take),
    .rx_byte    (in_ch.rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  fcbp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### sim/tb_framed_command_byte_parser_top.sv
// tb_framed_command_byte_parser_top: self-checking bench for the framed command byte parser
// drives byte, result and register channels, predicts every action and compares it
// depends on fcbp_pkg, the fcbp channel interfaces and framed_command_byte_parser_top
module tb_framed_command_byte_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned PhaseItems = 40;
  localparam int unsigned DirectedRows = 30;

  typedef struct packed {
    logic              reload;
    logic [7:0]        rx;
    logic              typed;
    logic              has_res;
    fcbp_pkg::result_t res;
  } plan_row_t;

  localparam fcbp_pkg::result_t NoAction = '0;
  localparam fcbp_pkg::cfg_t FrameCfg = '{16'hA55A, 8'h01, 8'h02, 8'h03,
                                          16'h8000, 16'hFFFF, 16'h0100, 16'h01FF};

  localparam plan_row_t DirectedPlan [DirectedRows] = '{
    '{1'b0, 8'h00, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'hFF, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'hFF, 1'b1, 1'b1,
      '{fcbp_pkg::ACT_PWM_WR, 16'h0000, 16'hFFFF, 8'h00, 8'h00, 1'b0}},
    '{1'b1, 8'hA5, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'h77, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'hA5, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'h5A, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'h77, 1'b1, 1'b0, NoAction},
    '{1'b0, 8'hA5, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h5A, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h02, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h12, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h34, 1'b1, 1'b1,
      '{fcbp_pkg::ACT_RD_REPLY, 16'h1234, fcbp_pkg::ReadFailWord, 8'h00, 8'h00, 1'b0}},
    '{1'b0, 8'hA5, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h5A, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h01, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'hA5, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h5A, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h03, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'hFF, 1'b0, 1'b0, NoAction},
    '{1'b0, 8'h00, 1'b0, 1'b0, NoAction}
  };

  logic clk = 1'b0;
  logic rst_n;

  fcbp_in_if  in_ch ();
  fcbp_out_if out_ch ();
  fcbp_cfg_if cfg_ch ();

  framed_command_byte_parser_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser mirror
  fcbp_pkg::cfg_t   live_cfg;
  fcbp_pkg::phase_t rx_phase;
  logic [7:0]       cmd_held;
  logic [15:0]      addr_held;
  logic [7:0]       val_hi;
  logic [7:0]       stream_len;
  logic [7:0]       stream_left;

  fcbp_pkg::result_t pending_actions [$];
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  logic              fixed_on = 1'b0;
  logic              fixed_has = 1'b0;
  fcbp_pkg::result_t fixed_res = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  function automatic fcbp_pkg::kind_t classify(logic [7:0] c);
    if (c == live_cfg.write_code) return fcbp_pkg::KIND_WRITE;
    if (c == live_cfg.read_code) return fcbp_pkg::KIND_READ;
    if (c == live_cfg.stream_code) return fcbp_pkg::KIND_STREAM;
    return fcbp_pkg::KIND_NONE;
  endfunction

  function automatic logic in_range(logic [15:0] a, logic [15:0] lo, logic [15:0] hi);
    return (a >= lo) && (a <= hi);
  endfunction

  task automatic parse_rx(input logic [7:0] b, output logic got,
                          output fcbp_pkg::result_t r);
    fcbp_pkg::kind_t k;
    got = 1'b0;
    r = '0;
    case (rx_phase)
      fcbp_pkg::PH_SYNC1: begin
        if (b == live_cfg.sync_word[15:8]) rx_phase = fcbp_pkg::PH_SYNC2;
      end
      fcbp_pkg::PH_SYNC2: begin
        rx_phase = (b == live_cfg.sync_word[7:0]) ? fcbp_pkg::PH_CMD : fcbp_pkg::PH_SYNC1;
      end
      fcbp_pkg::PH_CMD: begin
        cmd_held = b;
        rx_phase = (classify(b) != fcbp_pkg::KIND_NONE) ? fcbp_pkg::PH_ADDR1
                                                        : fcbp_pkg::PH_SYNC1;
      end
      fcbp_pkg::PH_ADDR1: begin
        addr_held = {b, 8'h00};
        rx_phase = fcbp_pkg::PH_ADDR2;
      end
      fcbp_pkg::PH_ADDR2: begin
        addr_held[7:0] = b;
        k = classify(cmd_held);
        rx_phase = fcbp_pkg::PH_SYNC1;
        if (k == fcbp_pkg::KIND_WRITE) begin
          rx_phase = fcbp_pkg::PH_VAL1;
        end else if (k == fcbp_pkg::KIND_STREAM) begin
          rx_phase = fcbp_pkg::PH_LEN;
        end else if (k == fcbp_pkg::KIND_READ) begin
          got = 1'b1;
          r.target_address = addr_held;
          if (in_range(addr_held, live_cfg.gpio_low, live_cfg.gpio_high)) begin
            r.action = fcbp_pkg::ACT_GPIO_RD;
          end else begin
            r.action = fcbp_pkg::ACT_RD_REPLY;
            r.data_word = fcbp_pkg::ReadFailWord;
          end
        end
      end
      fcbp_pkg::PH_VAL1: begin
        val_hi = b;
        rx_phase = fcbp_pkg::PH_VAL2;
      end
      fcbp_pkg::PH_VAL2: begin
        rx_phase = fcbp_pkg::PH_SYNC1;
        r.target_address = addr_held;
        r.data_word = {val_hi, b};
        if (in_range(addr_held, live_cfg.pwm_low, live_cfg.pwm_high)) begin
          got = 1'b1;
          r.action = fcbp_pkg::ACT_PWM_WR;
        end else if (in_range(addr_held, live_cfg.gpio_low, live_cfg.gpio_high)) begin
          got = 1'b1;
          r.action = fcbp_pkg::ACT_GPIO_WR;
        end
      end
      fcbp_pkg::PH_LEN: begin
        stream_len = b;
        stream_left = b;
        rx_phase = (b == 8'h00) ? fcbp_pkg::PH_SYNC1 : fcbp_pkg::PH_PAY;
      end
      fcbp_pkg::PH_PAY: begin
        got = 1'b1;
        r.action = fcbp_pkg::ACT_STREAM;
        r.target_address = addr_held;
        r.payload_byte = b;
        r.payload_length = stream_len;
        if (stream_left <= 8'd1) begin
          stream_left = 8'h00;
          rx_phase = fcbp_pkg::PH_SYNC1;
          r.last_of_stream = 1'b1;
        end else begin
          stream_left = stream_left - 8'd1;
        end
      end
      default: rx_phase = fcbp_pkg::PH_SYNC1;
    endcase
  endtask

  function automatic void log_failure(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : track
    logic              got;
    fcbp_pkg::result_t pred;
    fcbp_pkg::result_t want;
    if (!rst_n) begin
      live_cfg = '0;
      rx_phase = fcbp_pkg::PH_SYNC1;
      cmd_held = '0;
      addr_held = '0;
      val_hi = '0;
      stream_len = '0;
      stream_left = '0;
      pending_actions.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (fcbp_pkg::reg_idx_t'(cfg_ch.reg_index))
          fcbp_pkg::REG_SYNC_WORD:   live_cfg.sync_word = cfg_ch.wdata;
          fcbp_pkg::REG_WRITE_CODE:  live_cfg.write_code = cfg_ch.wdata[7:0];
          fcbp_pkg::REG_READ_CODE:   live_cfg.read_code = cfg_ch.wdata[7:0];
          fcbp_pkg::REG_STREAM_CODE: live_cfg.stream_code = cfg_ch.wdata[7:0];
          fcbp_pkg::REG_GPIO_LOW:    live_cfg.gpio_low = cfg_ch.wdata;
          fcbp_pkg::REG_GPIO_HIGH:   live_cfg.gpio_high = cfg_ch.wdata;
          fcbp_pkg::REG_PWM_LOW:     live_cfg.pwm_low = cfg_ch.wdata;
          fcbp_pkg::REG_PWM_HIGH:    live_cfg.pwm_high = cfg_ch.wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_actions.size() == 0) begin
          log_failure($sformatf("unexpected result: act=%0d addr=%h data=%h pay=%h len=%h last=%b",
                                out_ch.action, out_ch.target_address, out_ch.data_word,
                                out_ch.payload_byte, out_ch.payload_length,
                                out_ch.last_of_stream));
        end else begin
          want = pending_actions.pop_front();
          if (out_ch.action !== want.action || out_ch.target_address !== want.target_address ||
              out_ch.data_word !== want.data_word || out_ch.payload_byte !== want.payload_byte ||
              out_ch.payload_length !== want.payload_length ||
              out_ch.last_of_stream !== want.last_of_stream) begin
            log_failure($sformatf({"mismatch: exp act=%0d addr=%h data=%h pay=%h len=%h last=%b",
                                   " got act=%0d addr=%h data=%h pay=%h len=%h last=%b"},
                                  want.action, want.target_address, want.data_word,
                                  want.payload_byte, want.payload_length, want.last_of_stream,
                                  out_ch.action, out_ch.target_address, out_ch.data_word,
                                  out_ch.payload_byte, out_ch.payload_length,
                                  out_ch.last_of_stream));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        parse_rx(in_ch.rx_byte, got, pred);
        if (fixed_on) begin
          got = fixed_has;
          pred = fixed_res;
        end
        if (got) pending_actions.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    while (rx_phase != fcbp_pkg::PH_SYNC1) send_byte(8'($urandom));
    drain();
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic apply_settings(input fcbp_pkg::cfg_t c);
    fcbp_pkg::reg_idx_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = fcbp_pkg::reg_idx_t'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.reg_index <= idx;
      case (idx)
        fcbp_pkg::REG_SYNC_WORD:   cfg_ch.wdata <= c.sync_word;
        fcbp_pkg::REG_WRITE_CODE:  cfg_ch.wdata <= {8'h00, c.write_code};
        fcbp_pkg::REG_READ_CODE:   cfg_ch.wdata <= {8'h00, c.read_code};
        fcbp_pkg::REG_STREAM_CODE: cfg_ch.wdata <= {8'h00, c.stream_code};
        fcbp_pkg::REG_GPIO_LOW:    cfg_ch.wdata <= c.gpio_low;
        fcbp_pkg::REG_GPIO_HIGH:   cfg_ch.wdata <= c.gpio_high;
        fcbp_pkg::REG_PWM_LOW:     cfg_ch.wdata <= c.pwm_low;
        default:                   cfg_ch.wdata <= c.pwm_high;
      endcase
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic fcbp_pkg::cfg_t draw_settings(int unsigned ph);
    fcbp_pkg::cfg_t c;
    c.sync_word = 16'($urandom);
    c.write_code = 8'($urandom);
    c.read_code = c.write_code + 8'($urandom_range(1, 85));
    c.stream_code = c.read_code + 8'($urandom_range(1, 85));
    c.pwm_low = 16'($urandom);
    c.pwm_high = c.pwm_low + 16'($urandom_range(0, 1023));
    c.gpio_low = 16'($urandom);
    c.gpio_high = c.gpio_low + 16'($urandom_range(0, 4095));
    case (ph % 6)
      0: begin
        c.sync_word = 16'h0000;
        c.write_code = 8'h00;
        c.read_code = 8'($urandom_range(1, 85));
        c.stream_code = c.read_code + 8'($urandom_range(1, 85));
        c.gpio_low = 16'h0000;
        c.gpio_high = 16'hFFFF;
        c.pwm_low = 16'hFFFF;
        c.pwm_high = 16'h0000;
      end
      1: begin
        c.sync_word = 16'hFFFF;
        c.write_code = 8'hFF;
        c.read_code = 8'hFF;
        c.stream_code = 8'hFF;
        c.pwm_low = 16'h0000;
        c.pwm_high = 16'hFFFF;
      end
      2: c.read_code = c.write_code;
      3: c.stream_code = c.read_code;
      4: begin
        c.gpio_low = c.pwm_low - 16'h0010;
        c.gpio_high = c.pwm_high + 16'h0010;
      end
      default: begin
        c.sync_word = {2{c.sync_word[7:0]}};
        c.gpio_high = c.gpio_low - 16'h0001;
      end
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 11))
      0:       return live_cfg.pwm_low;
      1:       return live_cfg.pwm_high;
      2:       return live_cfg.pwm_low - 16'h0001;
      3:       return live_cfg.pwm_high + 16'h0001;
      4:       return live_cfg.gpio_low;
      5:       return live_cfg.gpio_high;
      6:       return live_cfg.gpio_low - 16'h0001;
      7:       return live_cfg.gpio_high + 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(output int unsigned sent);
    logic [7:0]  frame [$];
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [15:0] addr;
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 35) cmd = live_cfg.write_code;
    else if (pick < 60) cmd = live_cfg.read_code;
    else if (pick < 90) cmd = live_cfg.stream_code;
    else cmd = 8'($urandom);
    addr = pick_address();
    frame.push_back(live_cfg.sync_word[15:8]);
    frame.push_back(live_cfg.sync_word[7:0]);
    frame.push_back(cmd);
    frame.push_back(addr[15:8]);
    frame.push_back(addr[7:0]);
    if (pick < 35) begin
      frame.push_back(8'($urandom));
      frame.push_back(8'($urandom));
    end else if (pick >= 60 && pick < 90) begin
      len = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 4));
      frame.push_back(len);
      repeat (len) frame.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) frame.delete(frame.size() - 1);
      end else begin
        frame[1] = ~frame[1];
      end
    end
    foreach (frame[i]) send_byte(frame[i]);
    sent = frame.size();
  endtask

  initial begin
    plan_row_t   row;
    int unsigned ph;
    int unsigned phase_items;
    int unsigned rand_items;
    int unsigned sent;
    int unsigned drain_at;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = fcbp_pkg::REG_SYNC_WORD;
    cfg_ch.wdata = 16'h0000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirectedRows; i++) begin
      row = DirectedPlan[i];
      if (row.reload) begin
        fixed_on = 1'b0;
        settle();
        apply_settings(FrameCfg);
      end
      fixed_on = row.typed;
      fixed_has = row.has_res;
      fixed_res = row.res;
      send_byte(row.rx);
    end
    fixed_on = 1'b0;

    rand_items = 0;
    for (ph = 0; ph < 8 || rand_items < RandomItems; ph++) begin
      settle();
      apply_settings(draw_settings(ph));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 2) begin
        @(posedge clk);
        hold_left = HoldOffCycles;
        @(negedge clk);
      end
      drain_at = (ph == 3) ? PhaseItems / 2 : '1;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        if (phase_items >= drain_at) begin
          drain();
          drain_at = '1;
        end
        if ($urandom_range(0, 99) < 15) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
        send_frame(sent);
        phase_items += sent;
      end
      rand_items += phase_items;
    end

    drain();
    repeat (TailCycles) @(negedge clk);
    err_count += pending_actions.size();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
